[sv/mexp_pkg.sv]
// Shared types and constants for the modular exponentiation block.
`timescale 1ns / 1ps

package mexp_pkg;

	// Width of every external field and configuration register
	localparam int FIELD_BITS = 32;

	// Configuration register indexes
	localparam int CFG_IDX_BITS = 1;
	localparam logic [CFG_IDX_BITS-1:0] REG_MODULUS  = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] REG_EXPONENT = 1'b1;

	// Exponentiation sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RED,
		ST_CHK,
		ST_MUL,
		ST_SQR,
		ST_FIN
	} mexp_state_t;

endpackage

[sv/modular_exponentiation.sv]
// Top level: right-to-left square-and-multiply modular exponentiation.
//
// Usage: load modulus (index 0) and exponent (index 1) on the cfg port while
// the block is idle; both reset to 1. Each word on the s_ channel is a
// message; the m_ channel returns message^exponent mod modulus in tdata and
// a bad-modulus flag in tuser (power forced to 0 when modulus is zero).
// One word is worked on at a time; s_tready is high only while idle.
// Sequence: the message is first reduced by the multiplier. Each exponent
// bit up to the highest set one then costs a check state, a squaring
// (skipped after the highest set bit) and, for a set bit, a multiplication
// before it; the result then passes through the output register. A zero
// modulus skips the multiplier and goes straight to the output register.
// All steps share the single bit-serial multiplier.
// The result sits in an output register; while the receiver stalls the block
// may take one new word and holds its result until the register drains.
// Reset (arst_n, async, active low) clears control only; config resets to 1.
`timescale 1ns / 1ps

module modular_exponentiation import mexp_pkg::*; #(
	parameter int WORD_BITS = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// configuration write port
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [FIELD_BITS-1:0]   cfg_data,
	// input stream
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [FIELD_BITS-1:0]   s_tdata,   // [31:0] message
	// output stream
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [FIELD_BITS-1:0]   m_tdata,   // [31:0] power
	output logic                    m_tuser    // [0] bad_modulus
);

	logic [FIELD_BITS-1:0] modulus_q;
	logic [FIELD_BITS-1:0] exponent_q;
	logic [WORD_BITS-1:0]  mod_fit;
	logic [WORD_BITS-1:0]  one_mod;
	logic [WORD_BITS-1:0]  e_q;
	logic [WORD_BITS-1:0]  r_q;
	logic [WORD_BITS-1:0]  b_q;
	logic                  bad_q;
	logic                  out_valid_q;
	logic [FIELD_BITS-1:0] power_q;
	logic                  out_bad_q;
	mexp_state_t           state_q;
	mexp_state_t           state_d;
	logic                  mm_start;
	logic [WORD_BITS-1:0]  mm_a;
	logic [WORD_BITS-1:0]  mm_b;
	logic                  mm_done;
	logic [WORD_BITS-1:0]  mm_result;
	logic                  out_free;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q  <= FIELD_BITS'(1);
			exponent_q <= FIELD_BITS'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODULUS:  modulus_q  <= cfg_data;
				REG_EXPONENT: exponent_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign mod_fit  = WORD_BITS'(modulus_q);
	assign one_mod  = (mod_fit == WORD_BITS'(1)) ? '0 : WORD_BITS'(1);
	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);

	// Shared modular multiplier
	mexp_mulmod #(
		.WORD_BITS(WORD_BITS)
	) u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mm_start),
		.a      (mm_a),
		.b      (mm_b),
		.m      (mod_fit),
		.done   (mm_done),
		.result (mm_result)
	);

	// Sequencer next state and multiplier launch
	always_comb begin
		state_d  = state_q;
		mm_start = 1'b0;
		mm_a     = b_q;
		mm_b     = b_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					if (mod_fit == '0) begin
						state_d = ST_FIN;
					end else begin
						// reduce message: message * 1 mod m
						mm_start = 1'b1;
						mm_a     = WORD_BITS'(s_tdata);
						mm_b     = one_mod;
						state_d  = ST_RED;
					end
				end
			end
			ST_RED: begin
				if (mm_done) begin
					state_d = ST_CHK;
				end
			end
			ST_CHK: begin
				if (e_q == '0) begin
					state_d = ST_FIN;
				end else if (e_q[0]) begin
					mm_start = 1'b1;
					mm_a     = r_q;
					state_d  = ST_MUL;
				end else begin
					mm_start = 1'b1;
					state_d  = ST_SQR;
				end
			end
			ST_MUL: begin
				if (mm_done) begin
					if ((e_q >> 1) == '0) begin
						state_d = ST_FIN;
					end else begin
						mm_start = 1'b1;
						state_d  = ST_SQR;
					end
				end
			end
			ST_SQR: begin
				if (mm_done) begin
					state_d = ST_CHK;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Working registers: exponent shifter, result and running base
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					e_q   <= WORD_BITS'(exponent_q);
					bad_q <= (mod_fit == '0);
					r_q   <= (mod_fit == '0) ? '0 : one_mod;
				end
			end
			ST_RED: begin
				if (mm_done) begin
					b_q <= mm_result;
				end
			end
			ST_MUL: begin
				if (mm_done) begin
					r_q <= mm_result;
				end
			end
			ST_SQR: begin
				if (mm_done) begin
					b_q <= mm_result;
					e_q <= e_q >> 1;
				end
			end
			default: ;
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			power_q   <= FIELD_BITS'(r_q);
			out_bad_q <= bad_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = power_q;
	assign m_tuser  = out_bad_q;

endmodule

[sv/mexp_mulmod.sv]
// Bit-serial interleaved modular multiplier: one multiplier bit per cycle.
`timescale 1ns / 1ps

module mexp_mulmod import mexp_pkg::*; #(
	parameter int WORD_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [WORD_BITS-1:0] a,
	input  logic [WORD_BITS-1:0] b,
	input  logic [WORD_BITS-1:0] m,
	output logic                 done,
	output logic [WORD_BITS-1:0] result
);

	localparam int CW = $clog2(WORD_BITS);

	logic [WORD_BITS-1:0] a_q;
	logic [WORD_BITS-1:0] b_q;
	logic [WORD_BITS-1:0] acc_q;
	logic [CW-1:0]        cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [WORD_BITS-1:0] acc_dbl;
	logic [WORD_BITS-1:0] acc_nxt;

	// (x + y) mod m for x, y below m; the sum never leaves the word
	function automatic logic [WORD_BITS-1:0] add_mod(
		input logic [WORD_BITS-1:0] x,
		input logic [WORD_BITS-1:0] y,
		input logic [WORD_BITS-1:0] md
	);
		logic [WORD_BITS-1:0] gap;
		gap = md - y;
		if (x >= gap) begin
			return x - gap;
		end
		return x + y;
	endfunction

	// One step: double the accumulator, then add b if the top bit of a is set
	always_comb begin
		acc_dbl = add_mod(acc_q, acc_q, m);
		acc_nxt = a_q[WORD_BITS-1] ? add_mod(acc_dbl, b_q, m) : acc_dbl;
	end

	// Control: step counter, busy and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(WORD_BITS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: multiplier shifts out MSB first
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			a_q   <= {a_q[WORD_BITS-2:0], 1'b0};
			acc_q <= acc_nxt;
		end
	end

	assign done   = done_q;
	assign result = acc_q;

endmodule
